FILE: hdl/hcp_pkg.sv
`timescale 1ns / 1ps

package hcp_pkg;

    // Alphabet and character mapping
    localparam int ALPHABET    = 89;
    localparam int OFFSET      = 34;
    localparam int SYM_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int PROD_W      = 2 * SYM_W;
    localparam int SUM_W       = PROD_W + 1;

    // (code - OFFSET) mod ALPHABET, with code taken in offset binary (code + 128)
    localparam int SYM_BIAS    = 2 * ALPHABET - (1 << (CHAR_W - 1)) - OFFSET;
    localparam int SYM_ACC_W   = CHAR_W + 1;

    // Reciprocal for reduction mod ALPHABET (floor, so one correction step)
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP       = (1 << RECIP_SHIFT) / ALPHABET;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int RPROD_W     = SUM_W + RECIP_W;
    localparam int QUOT_W      = RPROD_W - RECIP_SHIFT;

    // Pair queue between front and back
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // Key derivation pipeline depth, and hold-off counter
    localparam int KEY_LAT     = 5;
    localparam int KCNT_W      = $clog2(KEY_LAT + 1);

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = SYM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_TL     = 3'd0,
        REG_KEY_TR     = 3'd1,
        REG_KEY_BL     = 3'd2,
        REG_KEY_BR     = 3'd3,
        REG_DIRECTION  = 3'd4
    } t_cfg_reg;

    typedef logic [SYM_W-1:0] t_sym;

    typedef struct packed {
        t_sym x;
        t_sym y;
    } t_pair;

    // Effective matrix handed from key unit to back end
    typedef struct packed {
        t_sym m00;
        t_sym m01;
        t_sym m10;
        t_sym m11;
        logic singular;
        logic ready;
    } t_key;

    typedef logic [(1 << SYM_W)-1:0][SYM_W-1:0] t_inv_tab;

    // Inverse table mod ALPHABET, built at elaboration; entry 0 unused
    function automatic t_inv_tab build_inv_tab();
        t_inv_tab tab;
        tab = '0;
        for (int i = 1; i < ALPHABET; i++) begin
            for (int j = 1; j < ALPHABET; j++) begin
                if (((i * j) % ALPHABET) == 1) begin
                    tab[i] = SYM_W'(j);
                end
            end
        end
        return tab;
    endfunction

    localparam t_inv_tab INV_TAB = build_inv_tab();

    // Key entry 0..127 down to 0..88
    function automatic t_sym red_key(input t_sym k);
        return (k >= SYM_W'(ALPHABET)) ? k - SYM_W'(ALPHABET) : k;
    endfunction

    // Additive inverse mod ALPHABET of a reduced value
    function automatic t_sym neg_sym(input t_sym k);
        return (k == '0) ? '0 : SYM_W'(ALPHABET) - k;
    endfunction

    // Reduce a value below 2*ALPHABET*ALPHABET mod ALPHABET:
    // quotient estimate by reciprocal, then one conditional subtract
    function automatic t_sym mod_alpha(input logic [SUM_W-1:0] p);
        logic [RPROD_W-1:0] prod;
        logic [QUOT_W-1:0]  quot;
        logic [SUM_W-1:0]   qm;
        logic [SUM_W-1:0]   rem;
        prod = RPROD_W'(p) * RPROD_W'(RECIP);
        quot = prod[RPROD_W-1:RECIP_SHIFT];
        qm   = SUM_W'(quot) * SUM_W'(ALPHABET);
        rem  = p - qm;
        if (rem >= SUM_W'(ALPHABET)) begin
            rem = rem - SUM_W'(ALPHABET);
        end
        return SYM_W'(rem);
    endfunction

    // Signed character code to symbol
    function automatic t_sym to_symbol(input logic [CHAR_W-1:0] code);
        logic [SYM_ACC_W-1:0] v;
        v = {1'b0, ~code[CHAR_W-1], code[CHAR_W-2:0]} + SYM_ACC_W'(SYM_BIAS);
        if (v >= SYM_ACC_W'(2 * ALPHABET)) begin
            v = v - SYM_ACC_W'(2 * ALPHABET);
        end
        if (v >= SYM_ACC_W'(ALPHABET)) begin
            v = v - SYM_ACC_W'(ALPHABET);
        end
        return SYM_W'(v);
    endfunction

endpackage

FILE: hdl/hcp_key.sv
`timescale 1ns / 1ps

module hcp_key (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hcp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hcp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output hcp_pkg::t_key                    o_key
);

    // Configuration registers
    hcp_pkg::t_sym r_k_tl, r_k_tr, r_k_bl, r_k_br;
    logic          r_dir;
    logic [hcp_pkg::KCNT_W-1:0] r_hold_cnt;

    // Derivation pipeline
    hcp_pkg::t_sym r_kr00, r_kr01, r_kr10, r_kr11;
    logic [hcp_pkg::PROD_W-1:0] r_ad, r_bc;
    hcp_pkg::t_sym r_det;
    hcp_pkg::t_sym r_inv;
    logic          r_sing3, r_sing4, r_sing5;
    logic [hcp_pkg::PROD_W-1:0] r_p00, r_p01, r_p10, r_p11;
    hcp_pkg::t_sym r_m00, r_m01, r_m10, r_m11;

    hcp_pkg::t_sym adm, bcm, det;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_tl <= hcp_pkg::SYM_W'(5);
            r_k_tr <= hcp_pkg::SYM_W'(4);
            r_k_bl <= hcp_pkg::SYM_W'(3);
            r_k_br <= hcp_pkg::SYM_W'(1);
            r_dir  <= 1'b0;
        end else if (i_cfg_we) begin
            case (hcp_pkg::t_cfg_reg'(i_cfg_idx))
                hcp_pkg::REG_KEY_TL:    r_k_tl <= i_cfg_data;
                hcp_pkg::REG_KEY_TR:    r_k_tr <= i_cfg_data;
                hcp_pkg::REG_KEY_BL:    r_k_bl <= i_cfg_data;
                hcp_pkg::REG_KEY_BR:    r_k_br <= i_cfg_data;
                hcp_pkg::REG_DIRECTION: r_dir  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Hold off new pairs until the matrix has run through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_cnt <= hcp_pkg::KCNT_W'(hcp_pkg::KEY_LAT);
        end else if (i_cfg_we) begin
            r_hold_cnt <= hcp_pkg::KCNT_W'(hcp_pkg::KEY_LAT);
        end else if (r_hold_cnt != '0) begin
            r_hold_cnt <= r_hold_cnt - 1'b1;
        end
    end

    // Determinant: difference of reduced cross products
    always_comb begin
        adm = hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_ad));
        bcm = hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_bc));
        det = (adm >= bcm) ? adm - bcm : adm + (hcp_pkg::SYM_W'(hcp_pkg::ALPHABET) - bcm);
    end

    always_ff @(posedge i_clk) begin
        // stage 1: reduce entries, cross products
        r_kr00 <= hcp_pkg::red_key(r_k_tl);
        r_kr01 <= hcp_pkg::red_key(r_k_tr);
        r_kr10 <= hcp_pkg::red_key(r_k_bl);
        r_kr11 <= hcp_pkg::red_key(r_k_br);
        r_ad   <= hcp_pkg::PROD_W'(hcp_pkg::red_key(r_k_tl))
                * hcp_pkg::PROD_W'(hcp_pkg::red_key(r_k_br));
        r_bc   <= hcp_pkg::PROD_W'(hcp_pkg::red_key(r_k_tr))
                * hcp_pkg::PROD_W'(hcp_pkg::red_key(r_k_bl));
        // stage 2: determinant
        r_det  <= det;
        // stage 3: inverse lookup, -1 stands in when singular
        if (r_det == '0) begin
            r_inv <= hcp_pkg::SYM_W'(hcp_pkg::ALPHABET - 1);
        end else begin
            r_inv <= hcp_pkg::INV_TAB[r_det];
        end
        r_sing3 <= r_dir && (r_det == '0);
        // stage 4: adjugate times inverse, or the key itself
        if (r_dir) begin
            r_p00 <= hcp_pkg::PROD_W'(r_kr11) * hcp_pkg::PROD_W'(r_inv);
            r_p01 <= hcp_pkg::PROD_W'(hcp_pkg::neg_sym(r_kr01)) * hcp_pkg::PROD_W'(r_inv);
            r_p10 <= hcp_pkg::PROD_W'(hcp_pkg::neg_sym(r_kr10)) * hcp_pkg::PROD_W'(r_inv);
            r_p11 <= hcp_pkg::PROD_W'(r_kr00) * hcp_pkg::PROD_W'(r_inv);
        end else begin
            r_p00 <= hcp_pkg::PROD_W'(r_kr00);
            r_p01 <= hcp_pkg::PROD_W'(r_kr01);
            r_p10 <= hcp_pkg::PROD_W'(r_kr10);
            r_p11 <= hcp_pkg::PROD_W'(r_kr11);
        end
        r_sing4 <= r_sing3;
        // stage 5: reduce
        r_m00   <= hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_p00));
        r_m01   <= hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_p01));
        r_m10   <= hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_p10));
        r_m11   <= hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_p11));
        r_sing5 <= r_sing4;
    end

    assign o_key = '{m00: r_m00, m01: r_m01, m10: r_m10, m11: r_m11,
                     singular: r_sing5, ready: (r_hold_cnt == '0)};

    // Settled determinant is a proper residue
    a_det_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold_cnt == '0) |-> (r_det < hcp_pkg::SYM_W'(hcp_pkg::ALPHABET)))
        else $error("determinant out of range");

    // Singular flag only ever set in decrypt mode
    a_sing_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_hold_cnt == '0) && r_sing5) |-> r_dir)
        else $error("singular flag raised in encrypt mode");

endmodule

FILE: hdl/hcp_front.sv
`timescale 1ns / 1ps

module hcp_front (
    input  logic                               i_in_valid,
    input  logic signed [hcp_pkg::CHAR_W-1:0]  i_first_char,
    input  logic signed [hcp_pkg::CHAR_W-1:0]  i_second_char,
    input  logic                               i_key_ready,
    input  logic                               i_q_full,
    output logic                               o_in_ready,
    output logic                               o_push,
    output hcp_pkg::t_pair                     o_push_data
);

    // Take a pair when the key is settled and the queue has room
    assign o_in_ready = i_key_ready && !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;

    // Character codes to symbols
    assign o_push_data = '{x: hcp_pkg::to_symbol(i_first_char),
                           y: hcp_pkg::to_symbol(i_second_char)};

endmodule

FILE: hdl/hcp_queue.sv
`timescale 1ns / 1ps

module hcp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hcp_pkg::t_pair  i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output hcp_pkg::t_pair  o_pop_data
);

    hcp_pkg::t_pair r_mem [hcp_pkg::QDEPTH];
    logic [hcp_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [hcp_pkg::QCNT_W-1:0] r_cnt;

    assign o_full     = (r_cnt == hcp_pkg::QCNT_W'(hcp_pkg::QDEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hcp_pkg::QCNT_W'(hcp_pkg::QDEPTH))
        else $error("queue count over depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue pushed when full or popped when empty");

endmodule

FILE: hdl/hcp_back.sv
`timescale 1ns / 1ps

module hcp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  hcp_pkg::t_pair                i_q_data,
    input  hcp_pkg::t_key                 i_key,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hcp_pkg::SYM_W-1:0]     o_out_first,
    output logic [hcp_pkg::SYM_W-1:0]     o_out_second,
    output logic                          o_key_singular
);

    logic r_v1, r_v2;
    logic [hcp_pkg::PROD_W-1:0] r_p00, r_p01, r_p10, r_p11;
    hcp_pkg::t_sym r_first, r_second;
    logic          r_sing;
    logic          en1, en2;

    // Stage enables: a stage moves when the one after it can take its data
    assign en2   = !r_v2 || i_out_ready;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_q_valid && en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_q_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage 1: matrix times symbol pair, four products
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p00 <= hcp_pkg::PROD_W'(i_key.m00) * hcp_pkg::PROD_W'(i_q_data.x);
            r_p01 <= hcp_pkg::PROD_W'(i_key.m01) * hcp_pkg::PROD_W'(i_q_data.y);
            r_p10 <= hcp_pkg::PROD_W'(i_key.m10) * hcp_pkg::PROD_W'(i_q_data.x);
            r_p11 <= hcp_pkg::PROD_W'(i_key.m11) * hcp_pkg::PROD_W'(i_q_data.y);
        end
    end

    // Stage 2: row sums, reduce, back to character codes
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_first  <= hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_p00) + hcp_pkg::SUM_W'(r_p01))
                      + hcp_pkg::SYM_W'(hcp_pkg::OFFSET);
            r_second <= hcp_pkg::mod_alpha(hcp_pkg::SUM_W'(r_p10) + hcp_pkg::SUM_W'(r_p11))
                      + hcp_pkg::SYM_W'(hcp_pkg::OFFSET);
            r_sing   <= i_key.singular;
        end
    end

    assign o_out_valid    = r_v2;
    assign o_out_first    = r_first;
    assign o_out_second   = r_second;
    assign o_key_singular = r_sing;

endmodule

FILE: hdl/hill_cipher_pair_mod89.sv
`timescale 1ns / 1ps

// 2x2 Hill cipher over an 89-symbol alphabet, one character pair per transaction.
// Input codes map to (code - 34) mod 89, output symbols map back to symbol + 34.
// Direction 0 encrypts with the key matrix; direction 1 decrypts with the adjugate
// times the inverse determinant, using 88 and raising key_singular when the
// determinant is zero mod 89. Throughput is one pair per cycle while the key is
// settled and i_out_ready is high; an accepted pair is written into the queue,
// then passes the product stage and the reduce stage into the output register.
// The effective matrix is rebuilt by a 5-stage key pipeline, so after reset and
// after any configuration write o_in_ready stays low until that pipeline settles.
// A 4-entry queue separates the input side from the arithmetic, so output stalls
// do not reach o_in_ready until it fills.
module hill_cipher_pair_mod89 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [hcp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [hcp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input pairs
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [hcp_pkg::CHAR_W-1:0]  i_first_char,
    input  logic signed [hcp_pkg::CHAR_W-1:0]  i_second_char,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [hcp_pkg::SYM_W-1:0]          o_out_first,
    output logic [hcp_pkg::SYM_W-1:0]          o_out_second,
    output logic                               o_key_singular
);

    hcp_pkg::t_key  key;
    hcp_pkg::t_pair push_data, pop_data;
    logic           push, pop, q_full, q_valid;

    hcp_key u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_key      (key)
    );

    hcp_front u_front (
        .i_in_valid    (i_in_valid),
        .i_first_char  (i_first_char),
        .i_second_char (i_second_char),
        .i_key_ready   (key.ready),
        .i_q_full      (q_full),
        .o_in_ready    (o_in_ready),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    hcp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_pop_data  (pop_data)
    );

    hcp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (pop_data),
        .i_key          (key),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_key_singular (o_key_singular)
    );

    // Result codes always land in the printable band 34..122
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_first >= hcp_pkg::SYM_W'(hcp_pkg::OFFSET)
                      && o_out_first <= hcp_pkg::SYM_W'(hcp_pkg::OFFSET + hcp_pkg::ALPHABET - 1)
                      && o_out_second >= hcp_pkg::SYM_W'(hcp_pkg::OFFSET)
                      && o_out_second <= hcp_pkg::SYM_W'(hcp_pkg::OFFSET + hcp_pkg::ALPHABET - 1)))
        else $error("result code out of range");

endmodule

FILE: test/tb_hill_cipher_pair_mod89.sv
`timescale 1ns / 1ps

module tb_hill_cipher_pair_mod89;

    import hcp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 60;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_REPORTS    = 10;
    localparam int KEY_CHANGE_GAP = 50;

    typedef struct packed {
        logic [SYM_W-1:0] first;
        logic [SYM_W-1:0] second;
        logic             singular;
    } t_code_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic signed [CHAR_W-1:0] i_first_char = '0;
    logic signed [CHAR_W-1:0] i_second_char = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic [SYM_W-1:0] o_out_first;
    logic [SYM_W-1:0] o_out_second;
    logic o_key_singular;

    // Local copy of the key registers, updated as they are written
    logic [SYM_W-1:0] key_reg [4] = '{7'd5, 7'd4, 7'd3, 7'd1};
    logic decrypt_mode = 1'b0;

    t_code_pair expected_codes[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int pairs_sent = 0;
    int results_checked = 0;
    int singular_results = 0;
    int key_settings = 0;
    int fail_count = 0;
    int reports = 0;

    hill_cipher_pair_mod89 u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_first_char   (i_first_char),
        .i_second_char  (i_second_char),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_key_singular (o_key_singular)
    );

    always #2 i_clk = ~i_clk;

    // Expected output codes for one character pair under the current key
    function automatic t_code_pair hill_transform(input logic [CHAR_W-1:0] c0,
                                                  input logic [CHAR_W-1:0] c1);
        int k[4];
        int m[4];
        int i, x, y, sx, sy, det, inv, base, e;
        t_code_pair r;
        for (i = 0; i < 4; i++) begin
            k[i] = int'(key_reg[i]) % ALPHABET;
        end
        sx = $signed(c0);
        sy = $signed(c1);
        x = (sx - OFFSET + 3 * ALPHABET) % ALPHABET;
        y = (sy - OFFSET + 3 * ALPHABET) % ALPHABET;
        r.singular = 1'b0;
        if (decrypt_mode) begin
            det = ((k[0] * k[3]) % ALPHABET + ALPHABET - (k[1] * k[2]) % ALPHABET) % ALPHABET;
            if (det == 0) begin
                inv = ALPHABET - 1;
                r.singular = 1'b1;
            end else begin
                // det^(p-2) mod p
                inv = 1;
                base = det;
                e = ALPHABET - 2;
                while (e != 0) begin
                    if (e & 1) begin
                        inv = (inv * base) % ALPHABET;
                    end
                    base = (base * base) % ALPHABET;
                    e = e >> 1;
                end
            end
            m[0] = (k[3] * inv) % ALPHABET;
            m[1] = (((ALPHABET - k[1]) % ALPHABET) * inv) % ALPHABET;
            m[2] = (((ALPHABET - k[2]) % ALPHABET) * inv) % ALPHABET;
            m[3] = (k[0] * inv) % ALPHABET;
        end else begin
            m = k;
        end
        r.first  = SYM_W'((m[0] * x + m[1] * y) % ALPHABET + OFFSET);
        r.second = SYM_W'((m[2] * x + m[3] * y) % ALPHABET + OFFSET);
        return r;
    endfunction

    // Receiver: random idling, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Transaction monitor: predict on input, check on output, watchdog
    always @(posedge i_clk) begin
        t_code_pair got;
        t_code_pair want;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                want = hill_transform(i_first_char, i_second_char);
                expected_codes.insert(expected_codes.size(), want);
                if (want.singular) begin
                    singular_results++;
                end
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_out_first, o_out_second, o_key_singular};
                if (expected_codes.size() == 0) begin
                    fail_count++;
                    if (reports < MAX_REPORTS) begin
                        $display("unexpected result: first=%0d second=%0d singular=%0d",
                                 got.first, got.second, got.singular);
                    end
                    reports++;
                end else begin
                    want = expected_codes.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (reports < MAX_REPORTS) begin
                            $display("mismatch on result %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     results_checked, want.first, want.second, want.singular,
                                     got.first, got.second, got.singular);
                        end
                        reports++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offer one pair, with a random gap first, and wait until it is taken
    task automatic send_pair(input logic [CHAR_W-1:0] c0, input logic [CHAR_W-1:0] c1);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_first_char <= c0;
        i_second_char <= c1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pairs_sent++;
    endtask

    // Stop offering and wait for every pending result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        // let the monitor log the last accepted pair first
        @(posedge i_clk);
        while (expected_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_KEY_TL:    key_reg[0] = data;
            REG_KEY_TR:    key_reg[1] = data;
            REG_KEY_BL:    key_reg[2] = data;
            REG_KEY_BR:    key_reg[3] = data;
            REG_DIRECTION: decrypt_mode = data[0];
            default: ;
        endcase
    endtask

    // Full key and direction load, only with the block idle
    task automatic load_key(input int k00, input int k01, input int k10, input int k11,
                            input bit dec);
        drain_results();
        write_reg(REG_KEY_TL, SYM_W'(k00));
        write_reg(REG_KEY_TR, SYM_W'(k01));
        write_reg(REG_KEY_BL, SYM_W'(k10));
        write_reg(REG_KEY_BR, SYM_W'(k11));
        write_reg(REG_DIRECTION, CFG_DATA_W'(dec));
        i_cfg_we <= 1'b0;
        key_settings++;
    endtask

    // Random key: mostly arbitrary, sometimes singular or at the extremes
    task automatic load_random_key();
        int pick, a, b, c;
        pick = $urandom_range(9);
        a = $urandom_range(ALPHABET - 1);
        b = $urandom_range(ALPHABET - 1);
        c = $urandom_range(ALPHABET - 1);
        case (pick)
            0: load_key(0, 0, 0, 0, $urandom_range(1));
            1: load_key(127, 127, 127, 127, $urandom_range(1));
            2, 3: load_key(a, b, (c * a) % ALPHABET, (c * b) % ALPHABET, $urandom_range(1));
            default: load_key($urandom_range(127), $urandom_range(127),
                              $urandom_range(127), $urandom_range(127), $urandom_range(1));
        endcase
    endtask

    // Reset key in encrypt mode, character codes at the edges of the range
    task automatic test_encrypt_edges();
        send_pair(8'sh80, 8'sh7f);
        send_pair(8'sh7f, 8'sh80);
        send_pair(8'd34, 8'd34);
        send_pair(8'd33, 8'd122);
        send_pair(8'd123, 8'd0);
        send_pair(8'shff, 8'd1);
        send_pair(8'h55, 8'haa);
    endtask

    // Reset key in decrypt mode: determinant negative before reduction
    task automatic test_decrypt_reset_key();
        load_key(5, 4, 3, 1, 1'b1);
        send_pair(8'd34, 8'd122);
        send_pair(8'sh80, 8'sh80);
        send_pair(8'sh7f, 8'sh7f);
        send_pair(8'haa, 8'h55);
    endtask

    // Singular keys and key entries above 88
    task automatic test_singular_and_wide_keys();
        load_key(2, 4, 1, 2, 1'b1);
        send_pair(8'd40, 8'd90);
        send_pair(8'sh80, 8'sh7f);
        send_pair(8'd0, 8'd0);
        load_key(2, 4, 1, 2, 1'b0);
        send_pair(8'd40, 8'd90);
        send_pair(8'sh7f, 8'sh80);
        load_key(0, 0, 0, 0, 1'b1);
        send_pair(8'd100, 8'd50);
        send_pair(8'shc0, 8'd7);
        load_key(127, 89, 100, 88, 1'b1);
        send_pair(8'd34, 8'd35);
        send_pair(8'sh80, 8'sh7f);
        send_pair(8'd122, 8'd60);
        load_key(127, 89, 100, 88, 1'b0);
        send_pair(8'd34, 8'd35);
        send_pair(8'shff, 8'sh80);
    endtask

    // Random pairs with a new random key every so often
    task automatic test_random_traffic(input int n_pairs, input int s_pct, input int r_pct);
        int i;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (i = 0; i < n_pairs; i++) begin
            if (i % KEY_CHANGE_GAP == 0) begin
                load_random_key();
            end
            send_pair(CHAR_W'($urandom), CHAR_W'($urandom));
        end
    endtask

    // Long receiver hold-off while pairs keep coming, then a full drain
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_key($urandom_range(127), $urandom_range(127), $urandom_range(127),
                 $urandom_range(127), 1'b1);
        hold_req = 1'b1;
        for (i = 0; i < 30; i++) begin
            send_pair(CHAR_W'($urandom), CHAR_W'($urandom));
        end
        drain_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encrypt_edges();
        test_decrypt_reset_key();
        test_singular_and_wide_keys();
        test_random_traffic(400, 7, 82);
        test_random_traffic(400, 82, 7);
        test_random_traffic(400, 0, 0);
        test_backpressure();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (expected_codes.size() != 0) begin
            fail_count += expected_codes.size();
            $display("%0d results never arrived", expected_codes.size());
        end
        $display("Sent %0d character pairs under %0d key loads in both directions;",
                 pairs_sent, key_settings);
        $display("%0d results checked, %0d with a singular key, %0d failures.",
                 results_checked, singular_results, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/hcp_pkg.sv
hdl/hcp_key.sv
hdl/hcp_front.sv
hdl/hcp_queue.sv
hdl/hcp_back.sv
hdl/hill_cipher_pair_mod89.sv
test/tb_hill_cipher_pair_mod89.sv
